FILE: design/rde_pkg.sv
// Shared types, opcodes and class codes for the decode and execute pipeline.
package rde_pkg;

   localparam int PC_WIDTH_DEFAULT = 16;
   localparam int PC_FIELD_WIDTH   = 16;

   localparam logic [5:0] OP_ADD  = 6'd0;
   localparam logic [5:0] OP_ADDI = 6'd1;
   localparam logic [5:0] OP_SUB  = 6'd2;
   localparam logic [5:0] OP_SUBI = 6'd3;
   localparam logic [5:0] OP_MUL  = 6'd4;
   localparam logic [5:0] OP_MULI = 6'd5;
   localparam logic [5:0] OP_OR   = 6'd6;
   localparam logic [5:0] OP_ORI  = 6'd7;
   localparam logic [5:0] OP_AND  = 6'd8;
   localparam logic [5:0] OP_ANDI = 6'd9;
   localparam logic [5:0] OP_XOR  = 6'd10;
   localparam logic [5:0] OP_XORI = 6'd11;
   localparam logic [5:0] OP_LDW  = 6'd12;
   localparam logic [5:0] OP_STW  = 6'd13;
   localparam logic [5:0] OP_BZ   = 6'd14;
   localparam logic [5:0] OP_BEQ  = 6'd15;
   localparam logic [5:0] OP_JR   = 6'd16;
   localparam logic [5:0] OP_HALT = 6'd17;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_SUB = 3'd1;
   localparam logic [2:0] ALU_MUL = 3'd2;
   localparam logic [2:0] ALU_OR  = 3'd3;
   localparam logic [2:0] ALU_AND = 3'd4;

   localparam logic [2:0] CLASS_ARITH   = 3'd0;
   localparam logic [2:0] CLASS_LOGIC   = 3'd1;
   localparam logic [2:0] CLASS_MEMORY  = 3'd2;
   localparam logic [2:0] CLASS_CONTROL = 3'd3;
   localparam logic [2:0] CLASS_ILLEGAL = 3'd4;

   typedef struct packed {
      logic [31:0]        instr_word;
      logic signed [31:0] rs_value;
      logic signed [31:0] rt_value;
      logic [15:0]        fetch_pc;
      logic [15:0]        branch_base_pc;
   } req_type;

   typedef struct packed {
      logic [5:0]         opcode;
      logic               register_form;
      logic [4:0]         rs_index;
      logic [4:0]         rt_index;
      logic [4:0]         rd_index;
      logic signed [15:0] immediate;
      logic signed [31:0] result_value;
      logic               is_load;
      logic               store_op;
      logic               redirect;
      logic [15:0]        next_pc;
      logic [2:0]         instr_class;
   } rsp_type;

   typedef struct packed {
      logic [2:0] alu_op;
      logic       is_alu;
      logic       is_mem;
      logic       is_bz;
      logic       is_beq;
      logic       is_jr;
   } ctl_type;

   typedef struct packed {
      rsp_type            info;
      ctl_type            ctl;
      logic signed [31:0] rs_value;
      logic signed [31:0] rt_value;
      logic [31:0]        operand_b;
      logic [15:0]        branch_base_pc;
   } dec_type;

   typedef struct packed {
      rsp_type            info;
      logic [31:0]        alu_result;
      logic [32:0]        addr_sum;
      logic [31:0]        rs_value;
      logic [15:0]        target_pc;
      logic               is_alu;
      logic               is_mem;
      logic               is_jr;
      logic               taken;
   } exe_type;

endpackage

FILE: design/risc_decode_execute_unit.sv
// Top level of the three-stage instruction decode and execute pipeline.
// This block accepts one instruction beat per clock while req_stall is low and returns its
// result beat through the decode, execute and resolve registers; the rate is set by the
// three stage registers, each of which takes a new beat whenever it is empty or its
// contents move on, and the clock is set by the 32 by 32 multiplier in the execute stage.
// Empty stages keep filling while a finished result waits, so req_stall rises only when
// every stage is full and rsp_stall is high.
module risc_decode_execute_unit
   import rde_pkg::*;
#(
   parameter int PC_WIDTH = PC_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    dec_valid;
   logic    dec_ready;
   logic    dec_in_ready;
   dec_type dec_data;
   logic    exe_valid;
   logic    exe_ready;
   exe_type exe_data;

   rde_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (dec_in_ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   rde_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_ready (exe_ready),
      .out_data  (exe_data)
   );

   rde_resolve #(
      .PC_WIDTH (PC_WIDTH)
   ) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exe_valid),
      .in_ready  (exe_ready),
      .in_data   (exe_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !dec_in_ready;

endmodule

FILE: design/rde_decode.sv
// Decode stage: splits the instruction word and selects the second operand.
module rde_decode
   import rde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output dec_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   dec_type data_ff;
   dec_type data_in;
   logic [5:0] opcode;
   ctl_type ctl;
   logic [2:0] cls;
   logic    regf;

   assign opcode = in_data.instr_word[31:26];

   always_comb begin
      ctl        = '0;
      ctl.alu_op = opcode[3:1];
      cls        = CLASS_ILLEGAL;
      unique case (opcode) inside
         OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MUL, OP_MULI: begin
            cls        = CLASS_ARITH;
            ctl.is_alu = 1'b1;
         end
         OP_OR, OP_ORI, OP_AND, OP_ANDI, OP_XOR, OP_XORI: begin
            cls        = CLASS_LOGIC;
            ctl.is_alu = 1'b1;
         end
         OP_LDW, OP_STW: begin
            cls        = CLASS_MEMORY;
            ctl.is_mem = 1'b1;
         end
         OP_BZ, OP_BEQ, OP_JR, OP_HALT: begin
            cls        = CLASS_CONTROL;
            ctl.is_bz  = (opcode == OP_BZ);
            ctl.is_beq = (opcode == OP_BEQ);
            ctl.is_jr  = (opcode == OP_JR);
         end
         default: begin
            cls = CLASS_ILLEGAL;
         end
      endcase
   end

   assign regf = ctl.is_alu && !opcode[0];

   always_comb begin
      data_in                    = '0;
      data_in.ctl                = ctl;
      data_in.info.opcode        = opcode;
      data_in.info.register_form = regf;
      data_in.info.rs_index      = in_data.instr_word[25:21];
      data_in.info.rt_index      = in_data.instr_word[20:16];
      data_in.info.rd_index      = regf ? in_data.instr_word[15:11] : 5'd0;
      data_in.info.immediate     = regf ? 16'sd0 : $signed(in_data.instr_word[15:0]);
      data_in.info.is_load       = (opcode == OP_LDW);
      data_in.info.store_op      = (opcode == OP_STW);
      data_in.info.next_pc       = in_data.fetch_pc;
      data_in.info.instr_class   = cls;
      data_in.rs_value           = in_data.rs_value;
      data_in.rt_value           = in_data.rt_value;
      data_in.operand_b          = regf ? in_data.rt_value
                                        : {{16{in_data.instr_word[15]}},
                                           in_data.instr_word[15:0]};
      data_in.branch_base_pc     = in_data.branch_base_pc;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/rde_execute.sv
// Execute stage: ALU with multiplier, address sum, branch compare and target add.
module rde_execute
   import rde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output exe_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   exe_type     data_ff;
   exe_type     data_in;
   logic [31:0] a_value;
   logic [31:0] b_value;
   logic [31:0] alu_value;
   logic [15:0] imm_bits;

   assign a_value  = in_data.rs_value;
   assign b_value  = in_data.operand_b;
   assign imm_bits = in_data.info.immediate;

   always_comb begin
      case (in_data.ctl.alu_op)
         ALU_ADD: alu_value = a_value + b_value;
         ALU_SUB: alu_value = a_value - b_value;
         ALU_MUL: alu_value = a_value * b_value;
         ALU_OR:  alu_value = a_value | b_value;
         ALU_AND: alu_value = a_value & b_value;
         default: alu_value = a_value ^ b_value;
      endcase
   end

   always_comb begin
      data_in            = '0;
      data_in.info       = in_data.info;
      data_in.alu_result = alu_value;
      data_in.addr_sum   = {a_value[31], a_value} + {{17{imm_bits[15]}}, imm_bits};
      data_in.rs_value   = a_value;
      data_in.target_pc  = in_data.branch_base_pc + imm_bits;
      data_in.is_alu     = in_data.ctl.is_alu;
      data_in.is_mem     = in_data.ctl.is_mem;
      data_in.is_jr      = in_data.ctl.is_jr;
      data_in.taken      = (in_data.ctl.is_bz && (in_data.rs_value == 32'sd0))
                        || (in_data.ctl.is_beq && (in_data.rs_value == in_data.rt_value));
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/rde_resolve.sv
// Resolve stage: word address rounding, next PC selection and the result register.
module rde_resolve
   import rde_pkg::*;
#(
   parameter int PC_WIDTH = PC_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  exe_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam int PcBits = (PC_WIDTH < PC_FIELD_WIDTH) ? PC_WIDTH : PC_FIELD_WIDTH;
   localparam logic [PC_FIELD_WIDTH-1:0] PcMask =
      PC_FIELD_WIDTH'((33'd1 << PcBits) - 33'd1);

   logic        valid_ff;
   logic        valid_in;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [32:0] addr_adj;
   logic [31:0] addr_word;
   logic [31:0] jump_adj;
   logic [15:0] pc_pick;

   // Signed division by four rounds toward zero, so negative values are biased first.
   assign addr_adj  = in_data.addr_sum + (in_data.addr_sum[32] ? 33'd3 : 33'd0);
   assign addr_word = {addr_adj[32], addr_adj[32:2]};
   assign jump_adj  = in_data.rs_value + (in_data.rs_value[31] ? 32'd3 : 32'd0);

   always_comb begin
      if (in_data.taken) begin
         pc_pick = in_data.target_pc;
      end else if (in_data.is_jr) begin
         pc_pick = jump_adj[17:2];
      end else begin
         pc_pick = in_data.info.next_pc;
      end
   end

   always_comb begin
      data_in          = in_data.info;
      data_in.redirect = in_data.taken || in_data.is_jr;
      data_in.next_pc  = pc_pick & PcMask;
      if (in_data.is_alu) begin
         data_in.result_value = in_data.alu_result;
      end else if (in_data.is_mem) begin
         data_in.result_value = addr_word;
      end else begin
         data_in.result_value = 32'sd0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: design/rde_checker.sv
// Port-level checks for the decode and execute pipeline and their binding.
module rde_checker
   import rde_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side is free");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not reach the result port in time");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind risc_decode_execute_unit rde_checker u_checker (.*);

FILE: bench/risc_decode_execute_unit_tb.sv
// Self-checking testbench for the decode and execute pipeline with random beats and stalls.
module risc_decode_execute_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import rde_pkg::*;

   localparam int PC_BITS      = PC_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1525;
   localparam int CALM_ITEMS   = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_instrs[$];
   rsp_type expected_results[$];
   int      drain_marks[$];
   int      issued = 0;
   int      mismatches = 0;
   int      quiet_cycles = 0;
   int      cycle_count = 0;
   int      req_idle_pct = 10;
   int      rsp_idle_pct = 10;
   int      req_gap = 0;
   int      rsp_hold = 0;
   bit      beat_taken = 1'b0;
   bit      progress;

   risc_decode_execute_unit #(.PC_WIDTH(PC_BITS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] wrap_pc(longint v);
      longint mask;
      mask = (longint'(1) << PC_BITS) - 1;
      return 16'(v & mask);
   endfunction

   function automatic rsp_type decode_execute(req_type r);
      rsp_type            o;
      logic [5:0]         op;
      logic [31:0]        b;
      logic signed [31:0] imm32;
      longint             addr_sum;
      o = '0;
      op = r.instr_word[31:26];
      o.opcode = op;
      o.register_form = (op <= OP_XOR) && !op[0];
      o.rs_index = r.instr_word[25:21];
      o.rt_index = r.instr_word[20:16];
      o.next_pc = wrap_pc(longint'(r.fetch_pc));
      o.instr_class = CLASS_ILLEGAL;
      if (o.register_form) begin
         o.rd_index = r.instr_word[15:11];
         imm32 = '0;
         b = r.rt_value;
      end else begin
         o.immediate = r.instr_word[15:0];
         imm32 = {{16{r.instr_word[15]}}, r.instr_word[15:0]};
         b = imm32;
      end
      case (op)
         OP_ADD, OP_ADDI: o.result_value = r.rs_value + b;
         OP_SUB, OP_SUBI: o.result_value = r.rs_value - b;
         OP_MUL, OP_MULI: o.result_value = r.rs_value * b;
         OP_OR, OP_ORI:   o.result_value = r.rs_value | b;
         OP_AND, OP_ANDI: o.result_value = r.rs_value & b;
         OP_XOR, OP_XORI: o.result_value = r.rs_value ^ b;
         OP_LDW, OP_STW: begin
            addr_sum = longint'(r.rs_value) + longint'(imm32);
            o.result_value = 32'(addr_sum / 4);
            o.is_load = (op == OP_LDW);
            o.store_op = (op == OP_STW);
            o.instr_class = CLASS_MEMORY;
         end
         OP_BZ, OP_BEQ, OP_JR, OP_HALT: begin
            o.instr_class = CLASS_CONTROL;
            if ((op == OP_BZ && r.rs_value == 0) ||
                (op == OP_BEQ && r.rs_value == r.rt_value)) begin
               o.redirect = 1'b1;
               o.next_pc = wrap_pc(longint'(r.branch_base_pc) + longint'(imm32));
            end else if (op == OP_JR) begin
               o.redirect = 1'b1;
               o.next_pc = wrap_pc(longint'(r.rs_value) / 4);
            end
         end
         default: ;
      endcase
      if (op <= OP_XORI) o.instr_class = (op < OP_OR) ? CLASS_ARITH : CLASS_LOGIC;
      return o;
   endfunction

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d at %0t: %s, expected %h, actual %h",
                  mismatches, $realtime, what, want, got);
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      string   bad;
      bad = "";
      if (expected_results.size() == 0) begin
         report_mismatch("result beat with nothing pending", '0, got);
         return;
      end
      want = expected_results.pop_front();
      if (got.opcode !== want.opcode) bad = {bad, " opcode"};
      if (got.register_form !== want.register_form) bad = {bad, " register_form"};
      if (got.rs_index !== want.rs_index) bad = {bad, " rs_index"};
      if (got.rt_index !== want.rt_index) bad = {bad, " rt_index"};
      if (got.rd_index !== want.rd_index) bad = {bad, " rd_index"};
      if (got.immediate !== want.immediate) bad = {bad, " immediate"};
      if (got.result_value !== want.result_value) bad = {bad, " result_value"};
      if (got.is_load !== want.is_load) bad = {bad, " is_load"};
      if (got.store_op !== want.store_op) bad = {bad, " store_op"};
      if (got.redirect !== want.redirect) bad = {bad, " redirect"};
      if (got.next_pc !== want.next_pc) bad = {bad, " next_pc"};
      if (got.instr_class !== want.instr_class) bad = {bad, " instr_class"};
      if (bad != "") report_mismatch({"field", bad}, want, got);
   endtask

   function automatic logic [31:0] encode_instr(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                                logic [15:0] low);
      return {op, rs, rt, low};
   endfunction

   task automatic push_instr(logic [31:0] word, logic [31:0] rs, logic [31:0] rt,
                             logic [15:0] fpc, logic [15:0] bpc);
      req_type r;
      r.instr_word = word;
      r.rs_value = rs;
      r.rt_value = rt;
      r.fetch_pc = fpc;
      r.branch_base_pc = bpc;
      pending_instrs.push_back(r);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'($urandom_range(0, 15)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 50;
      endcase
   endfunction

   task automatic build_stimulus();
      logic [31:0] word;
      logic [31:0] rs;
      logic [31:0] rt;
      logic [5:0]  op;
      push_instr(encode_instr(OP_ADD, 5'd31, 5'd0, 16'hFFFF), 32'h7FFF_FFFF, 32'd1,
                 16'hFFFF, 16'h0000);
      push_instr(encode_instr(OP_SUB, 5'd0, 5'd31, 16'h0000), 32'h8000_0000, 32'd1,
                 16'h0000, 16'hFFFF);
      push_instr(encode_instr(OP_MUL, 5'd1, 5'd2, 16'h1800), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 16'h1234, 16'h1233);
      push_instr(encode_instr(OP_MUL, 5'd3, 5'd4, 16'h2000), 32'hFFFF_FFFF, 32'h8000_0000,
                 16'h0001, 16'h0000);
      push_instr(encode_instr(OP_OR, 5'd5, 5'd6, 16'h3800), 32'hAAAA_5555, 32'h0F0F_0F0F,
                 16'h0002, 16'h0001);
      push_instr(encode_instr(OP_AND, 5'd7, 5'd8, 16'h4000), 32'hAAAA_5555, 32'h0F0F_0F0F,
                 16'h0003, 16'h0002);
      push_instr(encode_instr(OP_XOR, 5'd9, 5'd10, 16'h4800), 32'hAAAA_5555, 32'hFFFF_FFFF,
                 16'h0004, 16'h0003);
      push_instr(encode_instr(OP_ADDI, 5'd11, 5'd12, 16'h8000), 32'h0000_0000, 32'h1,
                 16'h0005, 16'h0004);
      push_instr(encode_instr(OP_SUBI, 5'd13, 5'd14, 16'h7FFF), 32'h8000_0000, 32'h2,
                 16'h0006, 16'h0005);
      push_instr(encode_instr(OP_MULI, 5'd15, 5'd16, 16'hFFFF), 32'h7FFF_FFFF, 32'h3,
                 16'h0007, 16'h0006);
      push_instr(encode_instr(OP_ORI, 5'd17, 5'd18, 16'h8000), 32'h0000_0000, 32'h4,
                 16'h0008, 16'h0007);
      push_instr(encode_instr(OP_ANDI, 5'd19, 5'd20, 16'h8001), 32'hFFFF_FFFF, 32'h5,
                 16'h0009, 16'h0008);
      push_instr(encode_instr(OP_XORI, 5'd21, 5'd22, 16'hFFFF), 32'h1234_5678, 32'h6,
                 16'h000A, 16'h0009);
      push_instr(encode_instr(OP_LDW, 5'd23, 5'd24, 16'h0000), 32'hFFFF_FFFB, 32'h7,
                 16'h000B, 16'h000A);
      push_instr(encode_instr(OP_LDW, 5'd25, 5'd26, 16'h8000), 32'h8000_0000, 32'h8,
                 16'h000C, 16'h000B);
      push_instr(encode_instr(OP_STW, 5'd27, 5'd28, 16'h7FFF), 32'h7FFF_FFFF, 32'h9,
                 16'h000D, 16'h000C);
      push_instr(encode_instr(OP_STW, 5'd29, 5'd30, 16'hFFFD), 32'h0000_0006, 32'hA,
                 16'h000E, 16'h000D);
      push_instr(encode_instr(OP_BZ, 5'd1, 5'd2, 16'h0001), 32'h0000_0000, 32'hB,
                 16'h0000, 16'hFFFF);
      push_instr(encode_instr(OP_BZ, 5'd3, 5'd4, 16'h0010), 32'h0000_0001, 32'h0,
                 16'h0101, 16'h0100);
      push_instr(encode_instr(OP_BEQ, 5'd5, 5'd6, 16'hFFFF), 32'h8000_0000, 32'h8000_0000,
                 16'h0001, 16'h0000);
      push_instr(encode_instr(OP_BEQ, 5'd7, 5'd8, 16'h0020), 32'h0000_0005, 32'h0000_0006,
                 16'h0201, 16'h0200);
      push_instr(encode_instr(OP_JR, 5'd9, 5'd10, 16'h0000), 32'hFFFF_FFF9, 32'h0,
                 16'h0301, 16'h0300);
      push_instr(encode_instr(OP_JR, 5'd11, 5'd12, 16'hFFFF), 32'h7FFF_FFFF, 32'h0,
                 16'h0401, 16'h0400);
      push_instr(encode_instr(OP_HALT, 5'd13, 5'd14, 16'h1234), 32'h0000_0000, 32'h0,
                 16'h0501, 16'h0500);
      push_instr(encode_instr(6'd18, 5'd15, 5'd16, 16'hFFFF), 32'h1111_1111, 32'h2222_2222,
                 16'h0601, 16'h0600);
      push_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      drain_marks.push_back(pending_instrs.size());
      drain_marks.push_back(pending_instrs.size() + RANDOM_ITEMS / 2);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         word = $urandom;
         op = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 17))
                                            : 6'($urandom_range(18, 63));
         word[31:26] = op;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: word[15:0] = 16'h8000;
               1: word[15:0] = 16'h7FFF;
               2: word[15:0] = 16'hFFFF;
               default: word[15:0] = 16'($urandom_range(0, 7));
            endcase
         end
         rs = pick_operand();
         rt = pick_operand();
         if (op == OP_BZ && $urandom_range(0, 1) == 1) rs = '0;
         if (op == OP_BEQ && $urandom_range(0, 1) == 1) rt = rs;
         push_instr(word, rs, rt, 16'($urandom), 16'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count % 128 == 0) begin
            req_idle_pct = pick_idle_pct();
            rsp_idle_pct = pick_idle_pct();
         end
         progress = 1'b0;
         if (req_valid && !req_stall) begin
            expected_results.push_back(decode_execute(req_data));
            beat_taken = 1'b1;
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
            progress = 1'b1;
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         beat_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (drain_marks.size() != 0 && issued == drain_marks[0] &&
                      expected_results.size() != 0) begin
            req_valid <= 1'b0;
         end else if (pending_instrs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_instrs.size() >= CALM_ITEMS &&
                      $urandom_range(0, 99) < req_idle_pct) begin
            req_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            if (drain_marks.size() != 0 && issued == drain_marks[0])
               void'(drain_marks.pop_front());
            req_data <= pending_instrs.pop_front();
            req_valid <= 1'b1;
            issued++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (pending_instrs.size() >= CALM_ITEMS &&
                   $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_hold = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("risc_decode_execute_unit_tb NOT OK");
      $finish;
   end

   initial begin
      build_stimulus();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      wait (pending_instrs.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("risc_decode_execute_unit_tb OK");
      end else begin
         $display("risc_decode_execute_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
